// ===== hw/rtl/rab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_pkg
// Shared defaults and constants for the ray / box slab test.
// ----------------------------------------------------------------------------
package rab_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int DIR_BITS_DEF   = 16;
  localparam int NUM_AXES       = 3;
  // one divider lane per slab plane: three lower corners, then three upper
  localparam int NUM_LANES      = 2 * NUM_AXES;

endpackage

// ===== hw/rtl/ray_aabb_slab_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// Pipelined slab test of one ray against one axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream in_*: one request per item carrying box corners, ray origin
//  (signed Q16.16) and ray direction (signed Q2.14) in in_tdata.
//  Output stream out_*: one result per request, in order: hit flag, entry
//  and exit parameters (signed Q16.16, saturated) in out_tdata.
//  The pipeline has one prepare stage, one restoring-divider stage per
//  quotient bit across six parallel lanes, one saturate stage, one reduce
//  stage and the output register. Throughput is one request per cycle
//  while the receiver does not stall the output.
//  Reset clears every valid bit; no result is pending after reset.
//  When the receiver holds out_tready low with a result waiting, the whole
//  pipeline freezes and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test
  import rab_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIR_BITS   = DIR_BITS_DEF,
  localparam int IN_W  = ((9 * COORD_BITS + 3 * DIR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((1 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, t_entry, t_exit
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CB = COORD_BITS;
  localparam int DB = DIR_BITS;
  localparam int FR = DIR_BITS - 2;
  localparam int W  = COORD_BITS + DIR_BITS + 2;
  localparam int NL = NUM_LANES;
  localparam int NA = NUM_AXES;

  logic en;

  // divider pipeline: index 0 is the prepare stage, index k after k steps
  logic          dv_r   [0:CB];
  logic [W-1:0]  rem_r  [0:CB][0:NL-1];
  logic [CB-1:0] quo_r  [0:CB][0:NL-1];
  logic [DB-1:0] den_r  [0:CB][0:NL-1];
  logic          neg_r  [0:CB][0:NL-1];
  logic          ovf_r  [0:CB][0:NL-1];
  logic          zero_r [0:CB][0:NA-1];
  logic          ins_r  [0:CB][0:NA-1];

  logic                 sa_v_r;
  logic signed [CB-1:0] t_r    [0:NL-1];
  logic                 sa_zero_r [0:NA-1];
  logic                 sa_ins_r  [0:NA-1];

  logic                 sb_v_r;
  logic signed [CB-1:0] near_r, far_r;
  logic                 miss_r;

  logic                 out_v_r;
  logic                 hit_r;
  logic signed [CB-1:0] entry_r, exit_r;

  assign en        = !(out_v_r && !out_tready);
  assign in_tready = en;

  // ---------------- prepare stage ----------------
  for (genvar l = 0; l < NL; l++) begin : g_prep
    logic signed [CB-1:0] corner, org;
    logic signed [DB-1:0] dir;
    logic signed [CB:0]   diff;
    logic [CB:0]          un;
    logic [DB-1:0]        ud;
    logic [W-1:0]         num, dsh;

    assign corner = in_tdata[l*CB +: CB];
    assign org    = in_tdata[(6 + (l % NA))*CB +: CB];
    assign dir    = in_tdata[9*CB + (l % NA)*DB +: DB];
    assign diff   = {corner[CB-1], corner} - {org[CB-1], org};
    assign un     = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
    assign ud     = dir[DB-1] ? DB'(-dir) : DB'(dir);
    assign num    = {{(W-CB-1-FR){1'b0}}, un, {FR{1'b0}}};
    assign dsh    = {{(W-DB-CB){1'b0}}, ud, {CB{1'b0}}};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= num;
        quo_r[0][l] <= '0;
        den_r[0][l] <= ud;
        neg_r[0][l] <= diff[CB] ^ dir[DB-1];
        ovf_r[0][l] <= (num >= dsh);
      end
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis_prep
    logic signed [CB-1:0] mn, mx, org;
    logic [DB-1:0]        dir;
    assign mn  = in_tdata[a*CB +: CB];
    assign mx  = in_tdata[(3 + a)*CB +: CB];
    assign org = in_tdata[(6 + a)*CB +: CB];
    assign dir = in_tdata[9*CB + a*DB +: DB];

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[0][a] <= (dir == '0);
        ins_r[0][a]  <= (mn <= org) && (org <= mx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_tvalid;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------
  for (genvar j = 0; j < CB; j++) begin : g_div
    localparam int BI = CB - 1 - j;
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [W:0]    trial;
      logic [W-1:0]  rem_nxt;
      logic [CB-1:0] quo_nxt;

      assign trial = {1'b0, rem_r[j][l]} - ({{(W+1-DB){1'b0}}, den_r[j][l]} << BI);

      always_comb begin
        rem_nxt = rem_r[j][l];
        quo_nxt = quo_r[j][l];
        if (!trial[W]) begin
          rem_nxt     = trial[W-1:0];
          quo_nxt[BI] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1][l] <= rem_nxt;
          quo_r[j+1][l] <= quo_nxt;
          den_r[j+1][l] <= den_r[j][l];
          neg_r[j+1][l] <= neg_r[j][l];
          ovf_r[j+1][l] <= ovf_r[j][l];
        end
      end
    end

    for (genvar a = 0; a < NA; a++) begin : g_flag
      always_ff @(posedge clk) begin
        if (en) begin
          zero_r[j+1][a] <= zero_r[j][a];
          ins_r[j+1][a]  <= ins_r[j][a];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end
  end

  // ---------------- saturate and apply sign ----------------
  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [CB-1:0] lim, mag;
    assign lim = neg_r[CB][l] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    assign mag = (ovf_r[CB][l] || quo_r[CB][l] > lim) ? lim : quo_r[CB][l];

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[l] <= neg_r[CB][l] ? -mag : mag;
      end
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_sat_flag
    always_ff @(posedge clk) begin
      if (en) begin
        sa_zero_r[a] <= zero_r[CB][a];
        sa_ins_r[a]  <= ins_r[CB][a];
      end
    end
  end

  // ---------------- order per axis, reduce over axes ----------------
  logic signed [CB-1:0] near_nxt, far_nxt;
  logic                 miss_nxt;

  always_comb begin
    logic signed [CB-1:0] lo, hi;
    near_nxt = {1'b1, {(CB-1){1'b0}}};
    far_nxt  = {1'b0, {(CB-1){1'b1}}};
    miss_nxt = 1'b0;
    for (int a = 0; a < NA; a++) begin
      lo = (t_r[a] < t_r[a+NA]) ? t_r[a] : t_r[a+NA];
      hi = (t_r[a] < t_r[a+NA]) ? t_r[a+NA] : t_r[a];
      if (sa_zero_r[a]) begin
        // flat direction: no limit, miss when origin sits outside the slab
        if (!sa_ins_r[a]) begin
          miss_nxt = 1'b1;
        end
      end else begin
        if (lo > near_nxt) begin
          near_nxt = lo;
        end
        if (hi < far_nxt) begin
          far_nxt = hi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
      miss_r <= miss_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= !miss_r && !(near_r > far_r) && !far_r[CB-1];
      entry_r <= near_r;
      exit_r  <= far_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r  <= dv_r[CB];
      sb_v_r  <= sa_v_r;
      out_v_r <= sb_v_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W-1-2*CB){1'b0}}, exit_r, entry_r, hit_r};

endmodule

// ===== hw/rtl/rab_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_checker
// Port-level checks for the ray / box slab test, bound to the top level.
// ----------------------------------------------------------------------------
module rab_checker
  import rab_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIR_BITS   = DIR_BITS_DEF,
  localparam int IN_W  = ((9 * COORD_BITS + 3 * DIR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((1 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic                         hit;
  logic signed [COORD_BITS-1:0] t_entry, t_exit;

  assign hit     = out_tdata[0];
  assign t_entry = out_tdata[COORD_BITS:1];
  assign t_exit  = out_tdata[2*COORD_BITS:COORD_BITS+1];

  // pending result holds while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the input side only stalls when a result is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !(out_tvalid && !out_tready))
    else $error("input ready does not follow output stall");

  // a hit needs an ordered, nonnegative interval
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit |-> (t_entry <= t_exit) && !t_exit[COORD_BITS-1])
    else $error("hit reported on an empty interval");

  // nothing pending right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an offered request carries defined data
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tdata))
    else $error("request data unknown");

endmodule

bind ray_aabb_slab_test rab_checker #(
  .COORD_BITS(COORD_BITS),
  .DIR_BITS  (DIR_BITS)
) u_rab_checker (.*);

// ===== verif/ray_aabb_slab_test_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_test_test
// Self-checking bench for the ray / box slab test: directed rows from a
// table, then random boxes and rays, each result compared in order against
// an in-bench fixed-point slab predictor. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test_test;
  import rab_pkg::*;

  localparam int CB    = COORD_BITS_DEF;
  localparam int DB    = DIR_BITS_DEF;
  localparam int FRAC  = DB - 2;
  localparam int IN_W  = ((9 * CB + 3 * DB + 7) / 8) * 8;
  localparam int OUT_W = ((1 + 2 * CB + 7) / 8) * 8;
  localparam int LAT   = CB + 4;
  localparam longint T_HI = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint T_LO = -T_HI - 1;

  typedef struct packed {
    logic signed [DB-1:0] dir_z, dir_y, dir_x;
    logic signed [CB-1:0] org_z, org_y, org_x;
    logic signed [CB-1:0] max_z, max_y, max_x;
    logic signed [CB-1:0] min_z, min_y, min_x;
  } ray_box_t;

  typedef struct packed {
    logic signed [CB-1:0] t_exit;
    logic signed [CB-1:0] t_entry;
    logic                 hit;
  } slab_res_t;

  typedef struct {
    ray_box_t  req;
    bit        known;
    slab_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  slab_res_t pending_hits[$];
  int  errors = 0;
  bit  calm = 1'b0;
  bit  done = 1'b0;

  ray_aabb_slab_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact (num << FRAC) / den, truncated toward zero, saturated
  function automatic longint plane_t(longint num, longint den);
    logic signed [127:0] q;
    q = ($signed({{64{num[63]}}, num}) <<< FRAC) / $signed({{64{den[63]}}, den});
    if (q > T_HI) return T_HI;
    if (q < T_LO) return T_LO;
    return longint'(q);
  endfunction

  function automatic slab_res_t slab_predict(ray_box_t r);
    longint tn, tf, mn, mx, og, d, ta, tb;
    bit miss;
    slab_res_t o;
    tn = T_LO;
    tf = T_HI;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      case (a)
        0: begin mn = r.min_x; mx = r.max_x; og = r.org_x; d = r.dir_x; end
        1: begin mn = r.min_y; mx = r.max_y; og = r.org_y; d = r.dir_y; end
        default: begin mn = r.min_z; mx = r.max_z; og = r.org_z; d = r.dir_z; end
      endcase
      if (d == 0) begin
        if (!(mn <= og && og <= mx)) miss = 1'b1;
      end else begin
        ta = plane_t(mn - og, d);
        tb = plane_t(mx - og, d);
        if ((ta < tb ? ta : tb) > tn) tn = (ta < tb ? ta : tb);
        if ((ta < tb ? tb : ta) < tf) tf = (ta < tb ? tb : ta);
      end
    end
    o.hit = !miss && !(tn > tf) && tf >= 0;
    o.t_entry = tn[CB-1:0];
    o.t_exit = tf[CB-1:0];
    return o;
  endfunction

  function automatic ray_box_t make_ray(longint lo, longint hi, longint o, int d);
    ray_box_t r;
    r.min_x = CB'(lo); r.min_y = CB'(lo); r.min_z = CB'(lo);
    r.max_x = CB'(hi); r.max_y = CB'(hi); r.max_z = CB'(hi);
    r.org_x = CB'(o); r.org_y = CB'(o); r.org_z = CB'(o);
    r.dir_x = DB'(d); r.dir_y = DB'(d); r.dir_z = DB'(d);
    return r;
  endfunction

  function automatic ray_box_t rand_ray();
    ray_box_t r;
    logic [CB-1:0] c;
    c = $urandom_range(0, 3) == 0 ? $urandom : ($urandom_range(0, 200) << 16);
    r = make_ray(0, 0, 0, 0);
    if ($urandom_range(0, 4) == 0) begin
      r = {16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // small well-formed box, origin near it, mostly nonzero directions
      r.min_x = $signed(c) - $urandom_range(0, 32'h40000);
      r.min_y = $signed(c) - $urandom_range(0, 32'h40000);
      r.min_z = $signed(c) - $urandom_range(0, 32'h40000);
      r.max_x = r.min_x + $urandom_range(0, 32'h80000);
      r.max_y = r.min_y + $urandom_range(0, 32'h80000);
      r.max_z = r.min_z + $urandom_range(0, 32'h80000);
      r.org_x = $signed(c) + $signed(32'($urandom_range(0, 32'h1000000))) - 32'h800000;
      r.org_y = $signed(c) + $signed(32'($urandom_range(0, 32'h1000000))) - 32'h800000;
      r.org_z = $signed(c) + $signed(32'($urandom_range(0, 32'h1000000))) - 32'h800000;
      r.dir_x = $urandom_range(0, 7) == 0 ? '0 : 16'($urandom);
      r.dir_y = $urandom_range(0, 7) == 0 ? '0 : 16'($urandom);
      r.dir_z = $urandom_range(0, 7) == 0 ? '0 : 16'($urandom);
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(ray_box_t r);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= IN_W'(r);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_hits.push_back(slab_predict(r));
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 37);

  always @(posedge clk) begin
    slab_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[1 + 2 * CB - 1:0];
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
          errors++;
        end
        if (got.t_entry !== want.t_entry) begin
          $display("%0t: t_entry exp %h got %h", $time, want.t_entry, got.t_entry);
          errors++;
        end
        if (got.t_exit !== want.t_exit) begin
          $display("%0t: t_exit exp %h got %h", $time, want.t_exit, got.t_exit);
          errors++;
        end
      end
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    slab_res_t open_res;
    ray_box_t r;
    open_res.hit = 1'b1;
    open_res.t_entry = T_LO[CB-1:0];
    open_res.t_exit = T_HI[CB-1:0];

    // zero direction, origin inside: no limit on any axis
    rows.push_back('{make_ray(-32'sh10000, 32'sh10000, 0, 0), 1'b1, open_res});
    // zero direction, origin outside: forced miss, no limits
    open_res.hit = 1'b0;
    rows.push_back('{make_ray(0, 32'sh10000, 32'sh20000, 0), 1'b1, open_res});
    // inverted slab with zero direction
    rows.push_back('{make_ray(32'sh10000, 0, 0, 0), 1'b1, open_res});
    // extremes of every field, saturating quotients, then plain and mixed cases
    rows.push_back('{make_ray(T_LO, T_HI, T_LO, 1), 1'b0, open_res});
    rows.push_back('{make_ray(T_LO, T_HI, T_HI, -1), 1'b0, open_res});
    rows.push_back('{make_ray(T_LO, T_HI, 0, -32768), 1'b0, open_res});
    rows.push_back('{make_ray(T_LO, T_HI, 0, 32767), 1'b0, open_res});
    rows.push_back('{make_ray(T_HI, T_LO, 0, 16384), 1'b0, open_res});
    rows.push_back('{make_ray(32'sh10000, 32'sh20000, 0, 16384), 1'b0, open_res});
    rows.push_back('{make_ray(32'sh10000, 32'sh20000, 32'sh30000, 16384), 1'b0, open_res});
    rows.push_back('{make_ray(-1, -1, -1, -1), 1'b0, open_res});
    r = make_ray(0, 32'sh10000, 32'sh8000, 16384);
    r.dir_y = '0;
    rows.push_back('{r, 1'b0, open_res});
    r = make_ray(-32'sh50000, 32'sh50000, 0, 0);
    r.dir_x = DB'(3); r.org_z = CB'(T_HI); r.dir_z = DB'(-7);
    rows.push_back('{r, 1'b0, open_res});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.known && slab_predict(row.req) !== row.res) begin
        $display("%0t: table row %0d exp %h pred %h", $time, i, row.res,
                 slab_predict(row.req));
        errors++;
      end
      send_request(row.req);
    end
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 220);
      send_request(rand_ray());
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    done = 1'b1;
  end

  initial begin
    fork
      wait (done);
      #2_000_000;
    join_any
    if (done && errors == 0 && pending_hits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rab_pkg.sv
hw/rtl/ray_aabb_slab_test.sv
hw/rtl/rab_checker.sv
verif/ray_aabb_slab_test_test.sv
